// ===== rtl/core/utf8_to_cp1251_decoder_defines.svh =====
// Assertion macros for the decoder checker.
`ifndef UTF8_TO_CP1251_DECODER_DEFINES_SVH
`define UTF8_TO_CP1251_DECODER_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define U2C_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous reset.
`define U2C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/u2c_pkg.sv =====
// Constants and helpers for the UTF-8 to Windows-1251 decoder.
package u2c_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UsedW = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [UsedW-1:0] used_t;

  // Lead bytes
  localparam byte_t LEAD_D0 = 8'hD0;
  localparam byte_t LEAD_D1 = 8'hD1;
  localparam byte_t LEAD_C2 = 8'hC2;
  localparam byte_t LEAD_E2 = 8'hE2;

  // Offsets and special codes
  localparam byte_t OFS_D0      = 8'h30;
  localparam byte_t OFS_D1      = 8'h70;
  localparam byte_t CONT_YO_UC  = 8'h81;
  localparam byte_t CONT_YO_LC  = 8'h91;
  localparam byte_t CODE_YO_UC  = 8'hA8;
  localparam byte_t CODE_YO_LC  = 8'hB8;
  localparam byte_t CONT_NUM_A  = 8'h84;
  localparam byte_t CONT_NUM_B  = 8'h96;
  localparam byte_t CODE_NUMERO = 8'hB9;
  localparam byte_t SPACE_CODE  = 8'h20;

  localparam used_t USED_ONE   = 2'd1;
  localparam used_t USED_TWO   = 2'd2;
  localparam used_t USED_THREE = 2'd3;

  // Keep the seven supported Latin-1 symbols, else space.
  function automatic byte_t map_c2(input byte_t b);
    byte_t r;
    case (b)
      8'hB0, 8'hA7, 8'hAB, 8'hBB, 8'hB1, 8'hB6, 8'hB7: r = b;
      default:                                         r = SPACE_CODE;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/utf8_to_cp1251_decoder.sv =====
// UTF-8 byte stream to Windows-1251 character decoder, top level.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_stall, in_byte    | in
//  result  | out_valid, out_stall, out_code,| out
//          | out_bytes_used                 |
//
// One byte per clock sustained while the result is not stalled; an accepted byte
// sits in the input register and is decoded into the result register once that
// register is free, so each result is registered behind the input register.
// Lead bytes and the first byte after 0xE2 give no result transaction; the decode
// step holds the sequence state.
// Synchronous active-low reset clears the valid flags and the sequence state.
// A stalled result holds; the input register still takes one byte behind it.
module utf8_to_cp1251_decoder
  import u2c_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_byte,
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_code,
  output used_t out_bytes_used
);

  typedef enum logic [2:0] {
    KIND_IDLE = 3'd0,
    KIND_D0   = 3'd1,
    KIND_D1   = 3'd2,
    KIND_C2   = 3'd3,
    KIND_E2A  = 3'd4,
    KIND_E2B  = 3'd5
  } kind_t;

  logic  in_vld_r;
  byte_t in_byte_r;
  kind_t kind_r, kind_nxt;
  logic  match_r, match_nxt;
  logic  out_vld_r;
  byte_t code_r, code_nxt;
  used_t used_r, used_nxt;
  logic  emit;
  logic  out_free;
  logic  fire;

  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  always_comb begin
    kind_nxt  = KIND_IDLE;
    match_nxt = 1'b0;
    emit      = 1'b1;
    code_nxt  = SPACE_CODE;
    used_nxt  = USED_TWO;
    unique case (kind_r)
      KIND_D0: begin
        if (in_byte_r >= 8'h90 && in_byte_r <= 8'hBF) begin
          code_nxt = in_byte_r + OFS_D0;
        end else if (in_byte_r == CONT_YO_UC) begin
          code_nxt = CODE_YO_UC;
        end
      end
      KIND_D1: begin
        if (in_byte_r >= 8'h80 && in_byte_r <= 8'h8F) begin
          code_nxt = in_byte_r + OFS_D1;
        end else if (in_byte_r == CONT_YO_LC) begin
          code_nxt = CODE_YO_LC;
        end
      end
      KIND_C2: begin
        code_nxt = map_c2(in_byte_r);
      end
      KIND_E2A: begin
        emit      = 1'b0;
        kind_nxt  = KIND_E2B;
        match_nxt = (in_byte_r == CONT_NUM_A);
      end
      KIND_E2B: begin
        used_nxt = USED_THREE;
        if (match_r && in_byte_r == CONT_NUM_B) begin
          code_nxt = CODE_NUMERO;
        end
      end
      default: begin
        used_nxt = USED_ONE;
        if (!in_byte_r[7]) begin
          code_nxt = in_byte_r;
        end else begin
          case (in_byte_r)
            LEAD_D0: begin emit = 1'b0; kind_nxt = KIND_D0;  end
            LEAD_D1: begin emit = 1'b0; kind_nxt = KIND_D1;  end
            LEAD_C2: begin emit = 1'b0; kind_nxt = KIND_C2;  end
            LEAD_E2: begin emit = 1'b0; kind_nxt = KIND_E2A; end
            default: code_nxt = SPACE_CODE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      kind_r    <= KIND_IDLE;
      match_r   <= 1'b0;
    end else begin
      // Input register: load on an accepted transaction, drain when decoded.
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        kind_r    <= kind_nxt;
        match_r   <= match_nxt;
        out_vld_r <= emit;
      end else if (out_free) begin
        out_vld_r <= 1'b0;
      end
    end
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
    if (fire && emit) begin
      code_r <= code_nxt;
      used_r <= used_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_code       = code_r;
  assign out_bytes_used = used_r;

endmodule

// ===== rtl/core/u2c_checker.sv =====
// Port-level checker for the decoder, bound to its top level.
`include "utf8_to_cp1251_decoder_defines.svh"

module u2c_checker
  import u2c_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_stall,
  input byte_t in_byte,
  input logic  out_valid,
  input logic  out_stall,
  input byte_t out_code,
  input used_t out_bytes_used
);

  `U2C_ASSERT_NOW(a_single_byte_ascii, clk, rst_n, out_valid && out_bytes_used == USED_ONE, !out_code[7], "single-byte result above 0x7F")

  `U2C_ASSERT_NOW(a_three_byte_code, clk, rst_n, out_valid && out_bytes_used == USED_THREE, out_code == CODE_NUMERO || out_code == SPACE_CODE, "three-byte result neither numero nor space")

  `U2C_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while result side free")

  `U2C_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_code) && $stable(out_bytes_used), "stalled result changed")

  `U2C_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_byte), "stalled input changed")

endmodule

bind utf8_to_cp1251_decoder u2c_checker u_u2c_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_byte        (in_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_code       (out_code),
  .out_bytes_used (out_bytes_used)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the UTF-8 to Windows-1251 decoder.
`timescale 1ns / 1ps

module tb;
  import u2c_pkg::*;

  localparam int unsigned CLK_PERIOD      = 12;
  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned LONG_HOLD       = 64;
  localparam int unsigned PHASE_BYTES     = 275;
  localparam int unsigned WATCHDOG_CYCLES = 200_000;

  // Decoder sequence state: what the next byte completes.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_AFTER_D0,
    SEQ_AFTER_D1,
    SEQ_AFTER_C2,
    SEQ_E2_FIRST,
    SEQ_E2_SECOND
  } seq_state_e;

  typedef struct packed {
    byte_t code;
    used_t used;
  } char_t;

  typedef struct packed {
    byte_t b;
    logic  has_exp;
    byte_t code;
    used_t used;
  } row_t;

  localparam byte_t LATIN_KEEP [7] = '{8'hA7, 8'hAB, 8'hB0, 8'hB1, 8'hB6, 8'hB7, 8'hBB};

  localparam int unsigned DIR_N = 25;
  localparam row_t DIRECTED [DIR_N] = '{
    '{8'h00,      1'b1, 8'h00,       USED_ONE},
    '{8'h7F,      1'b1, 8'h7F,       USED_ONE},
    '{8'h80,      1'b1, SPACE_CODE,  USED_ONE},
    '{8'hFF,      1'b1, SPACE_CODE,  USED_ONE},
    '{LEAD_D0,    1'b0, SPACE_CODE,  USED_ONE},
    '{8'h90,      1'b0, SPACE_CODE,  USED_ONE},
    '{LEAD_D0,    1'b0, SPACE_CODE,  USED_ONE},
    '{8'hBF,      1'b0, SPACE_CODE,  USED_ONE},
    '{LEAD_D0,    1'b0, SPACE_CODE,  USED_ONE},
    '{CONT_YO_UC, 1'b1, CODE_YO_UC,  USED_TWO},
    '{LEAD_D0,    1'b0, SPACE_CODE,  USED_ONE},
    '{8'h00,      1'b1, SPACE_CODE,  USED_TWO},
    '{LEAD_D1,    1'b0, SPACE_CODE,  USED_ONE},
    '{8'h80,      1'b0, SPACE_CODE,  USED_ONE},
    '{LEAD_D1,    1'b0, SPACE_CODE,  USED_ONE},
    '{8'h8F,      1'b0, SPACE_CODE,  USED_ONE},
    '{LEAD_D1,    1'b0, SPACE_CODE,  USED_ONE},
    '{CONT_YO_LC, 1'b1, CODE_YO_LC,  USED_TWO},
    '{LEAD_C2,    1'b0, SPACE_CODE,  USED_ONE},
    '{8'hB0,      1'b0, SPACE_CODE,  USED_ONE},
    '{LEAD_C2,    1'b0, SPACE_CODE,  USED_ONE},
    '{8'hC3,      1'b1, SPACE_CODE,  USED_TWO},
    '{LEAD_E2,    1'b0, SPACE_CODE,  USED_ONE},
    '{CONT_NUM_A, 1'b0, SPACE_CODE,  USED_ONE},
    '{CONT_NUM_B, 1'b1, CODE_NUMERO, USED_THREE}
  };

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  byte_t in_byte   = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t out_code;
  used_t out_bytes_used;

  seq_state_e  seq_state = SEQ_IDLE;
  logic        e2_saw_84 = 1'b0;
  char_t       cp1251_expected [$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_cnt = 0;

  utf8_to_cp1251_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code       (out_code),
    .out_bytes_used (out_bytes_used)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Advance the decoder state by one byte; return 1 when a character completes.
  function automatic bit decode_to_cp1251(input byte_t b, output char_t ch);
    ch.code = SPACE_CODE;
    ch.used = USED_ONE;
    case (seq_state)
      SEQ_AFTER_D0: begin
        ch.used = USED_TWO;
        if (b >= 8'h90 && b <= 8'hBF) ch.code = b + OFS_D0;
        else if (b == CONT_YO_UC) ch.code = CODE_YO_UC;
      end
      SEQ_AFTER_D1: begin
        ch.used = USED_TWO;
        if (b >= 8'h80 && b <= 8'h8F) ch.code = b + OFS_D1;
        else if (b == CONT_YO_LC) ch.code = CODE_YO_LC;
      end
      SEQ_AFTER_C2: begin
        ch.used = USED_TWO;
        foreach (LATIN_KEEP[i]) if (b == LATIN_KEEP[i]) ch.code = b;
      end
      SEQ_E2_FIRST: begin
        e2_saw_84 = (b == CONT_NUM_A);
        seq_state = SEQ_E2_SECOND;
        return 1'b0;
      end
      SEQ_E2_SECOND: begin
        ch.used = USED_THREE;
        if (e2_saw_84 && b == CONT_NUM_B) ch.code = CODE_NUMERO;
      end
      default: begin
        if (b < 8'h80) begin
          ch.code = b;
        end else if (b == LEAD_D0) begin
          seq_state = SEQ_AFTER_D0;
          return 1'b0;
        end else if (b == LEAD_D1) begin
          seq_state = SEQ_AFTER_D1;
          return 1'b0;
        end else if (b == LEAD_C2) begin
          seq_state = SEQ_AFTER_C2;
          return 1'b0;
        end else if (b == LEAD_E2) begin
          seq_state = SEQ_E2_FIRST;
          e2_saw_84 = 1'b0;
          return 1'b0;
        end
      end
    endcase
    seq_state = SEQ_IDLE;
    e2_saw_84 = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("%0t ns mismatch: %s got 0x%02h want 0x%02h", $time, what, got, want);
  endtask

  // Offer one byte, wait for the transaction, then record what it completes.
  task automatic send_byte(input byte_t b, input bit pinned = 1'b0,
                           input char_t pinned_ch = '0);
    char_t ch;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (decode_to_cp1251(b, ch)) cp1251_expected.push_back(pinned ? pinned_ch : ch);
  endtask

  // Mostly well-formed characters with random content, plus noise.
  task automatic play_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_byte(byte_t'($urandom_range(127)));
      end else if (pick < 45) begin
        send_byte(LEAD_D0);
        send_byte(pick < 41 ? byte_t'($urandom_range(8'hBF, 8'h80)) : byte_t'($urandom));
      end else if (pick < 60) begin
        send_byte(LEAD_D1);
        send_byte(pick < 56 ? byte_t'($urandom_range(8'h9F, 8'h80)) : byte_t'($urandom));
      end else if (pick < 72) begin
        send_byte(LEAD_C2);
        send_byte(pick < 66 ? LATIN_KEEP[$urandom_range(6)]
                            : byte_t'($urandom_range(8'hFF, 8'h80)));
      end else if (pick < 84) begin
        send_byte(LEAD_E2);
        if (pick < 80) begin
          send_byte(CONT_NUM_A);
          send_byte(CONT_NUM_B);
        end else begin
          send_byte($urandom_range(1) ? CONT_NUM_A : byte_t'($urandom));
          send_byte($urandom_range(1) ? CONT_NUM_B : byte_t'($urandom));
        end
      end else begin
        send_byte(byte_t'($urandom));
      end
    end
  endtask

  // Receiver: random stall, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cp1251_expected.size() == 0) begin
        report_mismatch("result with nothing pending, code", out_code, 8'h00);
      end else begin
        want = cp1251_expected.pop_front();
        if (out_code !== want.code) report_mismatch("code", out_code, want.code);
        if (out_bytes_used !== want.used)
          report_mismatch("bytes_used", 8'(out_bytes_used), 8'(want.used));
      end
    end
  end

  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

  initial begin
    send_idle_pct = 17;
    stall_pct <= 86;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_byte(DIRECTED[i].b, DIRECTED[i].has_exp, {DIRECTED[i].code, DIRECTED[i].used});
    play_random(PHASE_BYTES);

    send_idle_pct = 86;
    stall_pct <= 17;
    play_random(PHASE_BYTES);

    // Hold the result side while bytes keep coming, so the input backs up.
    send_idle_pct = 0;
    stall_pct <= 0;
    hold_req  <= ~hold_req;
    play_random(PHASE_BYTES);

    in_valid <= 1'b0;
    while (cp1251_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
